// ===== hw/rtl/address_range_table_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the address range table
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_TABLE_MACROS_SVH
`define ADDRESS_RANGE_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// clocked assertion, disabled while the active-low reset is asserted
`define ART_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked assertion that also holds during reset
`define ART_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ART_ASSERT(lbl, clk, rst_n, prop, msg)
`define ART_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/art_pkg.sv =====
// ----------------------------------------------------------------------------
// Address range table package
// Field widths, default sizes, command and status codes.
// ----------------------------------------------------------------------------
package art_pkg;

  // default configuration
  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned AddrBitsDef     = 32;

  // fixed field widths
  localparam int unsigned AddrFieldW = 32;
  localparam int unsigned LenW       = 16;
  localparam int unsigned HandleW    = 16;

  // command codes
  typedef enum logic [1:0] {
    CmdInsert         = 2'd0,
    CmdFindExact      = 2'd1,
    CmdFindContaining = 2'd2,
    CmdRemove         = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StOverlap  = 2'd1,
    StNotFound = 2'd2,
    StFull     = 2'd3
  } status_e;

endpackage

// ===== hw/rtl/address_range_table.sv =====
// ----------------------------------------------------------------------------
// Address range table
// Table of non-overlapping address ranges with insert, find and remove.
// ----------------------------------------------------------------------------
// All entries sit in one synchronous memory with a single read port, and every
// command scans the whole table through that port, one entry per cycle. An
// accepted transaction therefore runs through the scan and then a finish step
// that writes back and loads the output register; the finish step waits while
// the output register holds a result that is not taken, and only after it is
// the next transaction accepted, so one command is in flight at a time. After
// reset a clearing pass marks every entry free before the first transaction
// is accepted. The result register lets a new command start while an older
// result still waits on the output side.
// ----------------------------------------------------------------------------

`include "address_range_table_macros.svh"

module address_range_table #(
  parameter int unsigned TABLE_ENTRIES = art_pkg::TableEntriesDef,
  parameter int unsigned ADDRESS_BITS  = art_pkg::AddrBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic [art_pkg::AddrFieldW-1:0] address_i,
  input  logic [art_pkg::LenW-1:0]      range_length_i,
  input  logic [art_pkg::HandleW-1:0]   entry_handle_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [art_pkg::HandleW-1:0]   result_handle_o,
  output logic [1:0]                    status_o
);

  import art_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);
  localparam int unsigned AW   = ADDRESS_BITS;
  localparam int unsigned CmpW = (AW > LenW) ? AW : LenW;

  // controller states
  localparam logic [1:0] SClear  = 2'd0;
  localparam logic [1:0] SIdle   = 2'd1;
  localparam logic [1:0] SScan   = 2'd2;
  localparam logic [1:0] SFinish = 2'd3;

  typedef struct packed {
    logic               valid;
    logic [AW-1:0]      start;
    logic [LenW-1:0]    len;
    logic [HandleW-1:0] id;
  } entry_t;

  logic [1:0]         state_q, state_d;
  logic [IdxW-1:0]    scan_q, scan_d;

  // latched command
  cmd_e               cmd_q;
  logic [AW-1:0]      addr_q;
  logic [LenW-1:0]    len_q;
  logic [HandleW-1:0] handle_q;

  // scan results
  logic               ovl_q, ovl_d;
  logic               free_hit_q, free_hit_d;
  logic [IdxW-1:0]    free_idx_q, free_idx_d;
  logic               ex_hit_q, ex_hit_d;
  logic [IdxW-1:0]    ex_idx_q, ex_idx_d;
  logic [HandleW-1:0] ex_id_q, ex_id_d;
  logic               cov_hit_q, cov_hit_d;
  logic [HandleW-1:0] cov_id_q, cov_id_d;

  // output register
  logic               out_valid_q;
  logic               found_q;
  logic [HandleW-1:0] rhandle_q;
  status_e            status_q;

  // memory ports
  entry_t             entry_mem [TABLE_ENTRIES];
  entry_t             rdata_q;
  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  entry_t             mem_wdata;
  logic [IdxW-1:0]    mem_raddr;

  logic               in_fire;
  logic               out_free;
  logic               fin_load;
  logic [AW+AddrFieldW-1:0] addr_wide;

  // per-entry compare terms
  logic [AW-1:0]      diff_sa, diff_as;
  logic               hit_del, hit_rem, hit_exact, hit_cover;

  // finish-cycle result
  logic               res_found;
  logic [HandleW-1:0] res_handle;
  status_e            res_status;

  assign in_ready_o = (state_q == SIdle);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign fin_load   = (state_q == SFinish) & out_free;
  assign addr_wide  = {{AW{1'b0}}, address_i};

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= entry_mem[mem_raddr];
  end

  // read address: entry 0 on accept, next entry while scanning
  assign mem_raddr = in_fire ? '0 : scan_q + 1'b1;

  // compare the entry read this cycle against the latched command
  always_comb begin
    diff_sa   = rdata_q.start - addr_q;
    diff_as   = addr_q - rdata_q.start;
    hit_del   = (cmd_q == CmdInsert) & rdata_q.valid & (rdata_q.start >= addr_q) &
                (CmpW'(diff_sa) < CmpW'(len_q));
    hit_rem   = rdata_q.valid & ~hit_del;
    hit_exact = hit_rem & (rdata_q.start == addr_q);
    hit_cover = hit_rem & (rdata_q.start <= addr_q) &
                (CmpW'(diff_as) < CmpW'(rdata_q.len));
  end

  // result of the finished scan
  always_comb begin
    res_found  = 1'b0;
    res_handle = '0;
    res_status = StOk;
    case (cmd_q)
      CmdInsert: begin
        if (ovl_q) begin
          res_status = StOverlap;
        end else if (!free_hit_q) begin
          res_status = StFull;
        end
      end
      CmdFindExact: begin
        if (ex_hit_q) begin
          res_found  = 1'b1;
          res_handle = ex_id_q;
        end else begin
          res_status = StNotFound;
        end
      end
      CmdFindContaining: begin
        if (ex_hit_q) begin
          res_found  = 1'b1;
          res_handle = ex_id_q;
        end else if (cov_hit_q) begin
          res_found  = 1'b1;
          res_handle = cov_id_q;
        end else begin
          res_status = StNotFound;
        end
      end
      CmdRemove: begin
        if (!ex_hit_q) begin
          res_status = StNotFound;
        end
      end
      default: begin
        res_status = StOk;
      end
    endcase
  end

  // write port: clearing pass, deletions during scan, final update
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = scan_q;
    mem_wdata       = rdata_q;
    mem_wdata.valid = 1'b0;
    case (state_q)
      SClear: begin
        mem_we = 1'b1;
      end
      SScan: begin
        mem_we = hit_del;
      end
      SFinish: begin
        if (fin_load && cmd_q == CmdInsert && !ovl_q && free_hit_q) begin
          mem_we          = 1'b1;
          mem_waddr       = free_idx_q;
          mem_wdata.valid = 1'b1;
          mem_wdata.start = addr_q;
          mem_wdata.len   = len_q;
          mem_wdata.id    = handle_q;
        end else if (fin_load && cmd_q == CmdRemove && ex_hit_q) begin
          mem_we    = 1'b1;
          mem_waddr = ex_idx_q;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // controller and scan bookkeeping
  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    ovl_d      = ovl_q;
    free_hit_d = free_hit_q;
    free_idx_d = free_idx_q;
    ex_hit_d   = ex_hit_q;
    ex_idx_d   = ex_idx_q;
    ex_id_d    = ex_id_q;
    cov_hit_d  = cov_hit_q;
    cov_id_d   = cov_id_q;
    case (state_q)
      SClear: begin
        scan_d = scan_q + 1'b1;
        if (scan_q == LastIdx) begin
          scan_d  = '0;
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_fire) begin
          scan_d     = '0;
          ovl_d      = 1'b0;
          free_hit_d = 1'b0;
          ex_hit_d   = 1'b0;
          cov_hit_d  = 1'b0;
          state_d    = SScan;
        end
      end
      SScan: begin
        if (hit_exact || hit_cover) begin
          ovl_d = 1'b1;
        end
        if (!hit_rem && !free_hit_q) begin
          free_hit_d = 1'b1;
          free_idx_d = scan_q;
        end
        if (hit_exact && !ex_hit_q) begin
          ex_hit_d = 1'b1;
          ex_idx_d = scan_q;
          ex_id_d  = rdata_q.id;
        end
        if (hit_cover && !cov_hit_q) begin
          cov_hit_d = 1'b1;
          cov_id_d  = rdata_q.id;
        end
        scan_d = scan_q + 1'b1;
        if (scan_q == LastIdx) begin
          state_d = SFinish;
        end
      end
      SFinish: begin
        if (fin_load) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SClear;
      scan_q     <= '0;
      ovl_q      <= 1'b0;
      free_hit_q <= 1'b0;
      ex_hit_q   <= 1'b0;
      cov_hit_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      ovl_q      <= ovl_d;
      free_hit_q <= free_hit_d;
      ex_hit_q   <= ex_hit_d;
      cov_hit_q  <= cov_hit_d;
    end
  end

  // scan payload, no reset needed
  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d;
    ex_idx_q   <= ex_idx_d;
    ex_id_q    <= ex_id_d;
    cov_id_q   <= cov_id_d;
  end

  // latch the accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q    <= cmd_e'(command_i);
      addr_q   <= addr_wide[AW-1:0];
      len_q    <= range_length_i;
      handle_q <= entry_handle_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      found_q   <= res_found;
      rhandle_q <= res_handle;
      status_q  <= res_status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign result_handle_o = rhandle_q;
  assign status_o        = status_q;

  // checks
  `ART_ASSERT(a_load_after_scan, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == SFinish), "result loaded outside finish cycle")
  `ART_ASSERT(a_found_is_ok, clk_i, rst_ni, (out_valid_q && found_q) |-> (status_q == StOk), "found result with error status")
  `ART_ASSERT(a_accept_starts_scan, clk_i, rst_ni, in_fire |=> (state_q == SScan && scan_q == '0), "accepted transaction did not start a scan")

endmodule

// ===== sim/art_table_checker.sv =====
// ----------------------------------------------------------------------------
// Address range table checker
// Watches the command and result channels, keeps its own copy of the range
// table, predicts one result per accepted command and compares it field by
// field with the results that come back, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module art_table_checker #(
  parameter int unsigned Slots = art_pkg::TableEntriesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [1:0]                     command_i,
  input  logic [art_pkg::AddrFieldW-1:0] address_i,
  input  logic [art_pkg::LenW-1:0]       range_length_i,
  input  logic [art_pkg::HandleW-1:0]    entry_handle_i,
  // result channel
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           found_i,
  input  logic [art_pkg::HandleW-1:0]    result_handle_i,
  input  logic [1:0]                     status_i,
  // tallies for the testbench top
  output int                             errors_o,
  output int                             pending_o
);

  import art_pkg::*;

  typedef struct packed {
    logic               found;
    logic [HandleW-1:0] handle;
    status_e            status;
  } table_reply_t;

  // shadow copy of the range table, empty at the start of simulation
  bit                  slot_used [Slots];
  logic [AddrFieldW-1:0] slot_base [Slots];
  logic [LenW-1:0]     slot_len  [Slots];
  logic [HandleW-1:0]  slot_tag  [Slots];

  table_reply_t expected_replies[$];
  int           fail_tally = 0;

  assign errors_o  = fail_tally;
  assign pending_o = expected_replies.size();

  // slot whose range starts exactly at a, or -1
  function automatic int slot_at(logic [AddrFieldW-1:0] a);
    for (int i = 0; i < Slots; i++) begin
      if (slot_used[i] && slot_base[i] == a) return i;
    end
    return -1;
  endfunction

  // exact start wins, otherwise the slot whose range covers a, or -1
  function automatic int slot_covering(logic [AddrFieldW-1:0] a);
    int hit;
    hit = slot_at(a);
    if (hit >= 0) return hit;
    for (int i = 0; i < Slots; i++) begin
      // base <= a, so the difference cannot wrap, even where the range end passes 32 bits
      if (slot_used[i] && slot_base[i] <= a &&
          (a - slot_base[i]) < {{(AddrFieldW-LenW){1'b0}}, slot_len[i]}) return i;
    end
    return -1;
  endfunction

  // apply one command to the shadow table and return its reply
  function automatic table_reply_t apply_command(cmd_e cmd, logic [AddrFieldW-1:0] a,
                                                 logic [LenW-1:0] len,
                                                 logic [HandleW-1:0] tag);
    table_reply_t r;
    int           k;
    r = '{found: 1'b0, handle: '0, status: StOk};
    case (cmd)
      CmdInsert: begin
        // drop every entry that starts inside the new range
        for (int i = 0; i < Slots; i++) begin
          if (slot_used[i] && slot_base[i] >= a &&
              (slot_base[i] - a) < {{(AddrFieldW-LenW){1'b0}}, len}) slot_used[i] = 0;
        end
        if (slot_covering(a) >= 0) begin
          r.status = StOverlap;
        end else begin
          k = -1;
          for (int i = 0; i < Slots; i++) begin
            if (!slot_used[i]) begin
              k = i;
              break;
            end
          end
          if (k < 0) begin
            r.status = StFull;
          end else begin
            slot_used[k] = 1;
            slot_base[k] = a;
            slot_len[k]  = len;
            slot_tag[k]  = tag;
          end
        end
      end
      CmdFindExact, CmdFindContaining: begin
        k = (cmd == CmdFindExact) ? slot_at(a) : slot_covering(a);
        if (k >= 0) begin
          r.found  = 1'b1;
          r.handle = slot_tag[k];
        end else begin
          r.status = StNotFound;
        end
      end
      default: begin
        k = slot_at(a);
        if (k >= 0) slot_used[k] = 0;
        else r.status = StNotFound;
      end
    endcase
    return r;
  endfunction

  // predict on each accepted command, compare on each accepted result
  always @(posedge clk_i) begin : watch
    table_reply_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_replies.push_back(apply_command(cmd_e'(command_i), address_i,
                                                 range_length_i, entry_handle_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          $error("result transaction with no command outstanding");
          fail_tally++;
        end else begin
          want = expected_replies.pop_front();
          if (found_i !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found_i);
            fail_tally++;
          end
          if (result_handle_i !== want.handle) begin
            $error("result_handle: expected 0x%04h, actual 0x%04h",
                   want.handle, result_handle_i);
            fail_tally++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            fail_tally++;
          end
        end
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Address range table testbench
// Drives directed and random command sequences with random idle cycles on
// both channels; the checker beside the block predicts and compares every
// result, and this top reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import art_pkg::*;

  localparam int ItemTarget    = 1850;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 40;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            command_i      = '0;
  logic [AddrFieldW-1:0] address_i      = '0;
  logic [LenW-1:0]       range_length_i = '0;
  logic [HandleW-1:0]    entry_handle_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic                  found_o;
  logic [HandleW-1:0]    result_handle_o;
  logic [1:0]            status_o;

  int errors;
  int pending;
  int items_sent   = 0;
  int stall_cycles = 0;
  bit no_idle      = 0;

  logic [AddrFieldW-1:0] window_base;
  logic [AddrFieldW-1:0] recent_starts[$];

  always #5 clk_i = ~clk_i;

  address_range_table dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .command_i, .address_i, .range_length_i, .entry_handle_i,
    .out_valid_o, .out_ready_i, .found_o, .result_handle_o, .status_o
  );

  art_table_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .command_i, .address_i, .range_length_i,
    .entry_handle_i,
    .out_valid_i(out_valid_o), .out_ready_i, .found_i(found_o),
    .result_handle_i(result_handle_o), .status_i(status_o),
    .errors_o(errors), .pending_o(pending)
  );

  // result side: random backpressure
  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= 33);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("** address_range_table: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one command transaction, with random idle cycles ahead of it
  task automatic send_cmd(cmd_e cmd, logic [AddrFieldW-1:0] addr, logic [LenW-1:0] len,
                          logic [HandleW-1:0] tag);
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    address_i      <= addr;
    range_length_i <= len;
    entry_handle_i <= tag;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (cmd == CmdInsert) begin
      recent_starts.push_back(addr);
      if (recent_starts.size() > 24) void'(recent_starts.pop_front());
    end
  endtask

  // hold the sender until every outstanding result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // probe near a known start half of the time, else somewhere in the window
  function automatic logic [AddrFieldW-1:0] near_address();
    if (recent_starts.size() > 0 && $urandom_range(0, 1) == 1)
      return recent_starts[$urandom_range(0, recent_starts.size() - 1)]
             + $urandom_range(0, 8) - 2;
    return window_base + $urandom_range(0, 16'h3FFF);
  endfunction

  function automatic logic [AddrFieldW-1:0] pick_window();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 32'hFFFF_C000;
      2:       return $urandom & 32'hFFFF_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n;
    int step;
    logic [LenW-1:0] len;

    window_base = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, zero length, deletion by insert
    send_cmd(CmdFindExact, 32'h0000_0000, 16'h0000, 16'h0000);      // miss on empty table
    send_cmd(CmdRemove, 32'h0000_0000, 16'hFFFF, 16'hFFFF);         // remove absent start
    send_cmd(CmdInsert, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
    send_cmd(CmdInsert, 32'hFFFF_FFFF, 16'hFFFF, 16'h1234);         // end past 32 bits
    send_cmd(CmdFindExact, 32'h0000_0000, 16'h0000, 16'h0000);
    send_cmd(CmdFindContaining, 32'h0000_FFFE, 16'h0000, 16'h0000); // last covered address
    send_cmd(CmdFindContaining, 32'h0000_FFFF, 16'h0000, 16'h0000); // one past the end
    send_cmd(CmdFindContaining, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
    send_cmd(CmdInsert, 32'h0000_0100, 16'h0010, 16'h0001);         // start inside a range
    send_cmd(CmdInsert, 32'h0002_0000, 16'h0000, 16'hAAAA);         // empty range stored
    send_cmd(CmdInsert, 32'h0002_0000, 16'h0000, 16'h5555);         // empty, same start
    send_cmd(CmdInsert, 32'h0000_0050, 16'h0000, 16'h0002);         // empty, covered start
    send_cmd(CmdFindContaining, 32'h0002_0000, 16'h0000, 16'h0000); // exact start of empty
    send_cmd(CmdInsert, 32'h0000_0000, 16'hFFFF, 16'h5555);         // replaces range at 0
    send_cmd(CmdInsert, 32'h0000_0000, 16'h0000, 16'h0003);         // empty over deletion
    send_cmd(CmdRemove, 32'hFFFF_FFFF, 16'h0000, 16'h0000);

    // results all back before random traffic starts
    wait_drained();

    // random: fill bursts, mixed traffic around known starts, and noise
    while (items_sent < ItemTarget) begin
      no_idle = (items_sent >= 900 && items_sent < 1200);
      if ($urandom_range(0, 39) == 0) wait_drained();
      window_base = pick_window();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // fill the table with mostly disjoint ranges, 14 to 20 inserts per burst
          n    = $urandom_range(14, 20);
          step = $urandom_range(1, 16'h400);
          for (int k = 0; k < n; k++) begin
            send_cmd(CmdInsert, window_base + k * step, LenW'($urandom_range(0, step)),
                     HandleW'($urandom_range(0, 16'hFFFF)));
          end
        end
        3, 4, 5, 6, 7: begin
          for (int k = 0; k < 24; k++) begin
            len = ($urandom_range(0, 7) == 0) ? LenW'($urandom_range(0, 16'hFFFF))
                                              : LenW'($urandom_range(0, 16'h1FF));
            send_cmd(cmd_e'($urandom_range(0, 3)), near_address(), len,
                     HandleW'($urandom_range(0, 16'hFFFF)));
          end
        end
        default: begin
          for (int k = 0; k < 6; k++) begin
            send_cmd(cmd_e'($urandom_range(0, 3)), $urandom,
                     LenW'($urandom_range(0, 16'hFFFF)),
                     HandleW'($urandom_range(0, 16'hFFFF)));
          end
        end
      endcase
    end
    no_idle = 0;

    // drain and let any stray result show up
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("** address_range_table: PASSED **");
    end else begin
      $display("** address_range_table: FAILED **");
    end
    $finish;
  end

endmodule
